@@ hdl/dosf_pkg.sv @@
`default_nettype none
package dosf_pkg;

  // Ring geometry.
  localparam int DEPTH    = 1024;
  localparam int MAX_TAKE = 64;
  localparam int PTR_W    = $clog2(DEPTH);
  localparam int CNT_W    = PTR_W + 1;
  localparam int TAKE_W   = $clog2(MAX_TAKE + 1);
  localparam int TOT_W    = 48;
  localparam int SMP_W    = 32;
  localparam int MAXC_W   = 7;
  localparam int FUNC_W   = 2;
  localparam int KIND_W   = 2;

  localparam logic [CNT_W-1:0] CAP_RESET = (DEPTH < 1024) ? CNT_W'(DEPTH) : CNT_W'(1024);
  localparam logic [TOT_W-1:0] TOT_MAX   = {TOT_W{1'b1}};

  // Operation codes on the input side.
  localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TAKE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  // Result kinds on the output side.
  localparam logic [KIND_W-1:0] KIND_PUSH  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DATA  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd3;

  // Input tdata layout.
  localparam int IN_BITS     = SMP_W + MAXC_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

  // Output tdata layout, lowest field first.
  localparam int O_SMP_LO    = 0;
  localparam int O_DROP      = O_SMP_LO + SMP_W;
  localparam int O_FILL_LO   = O_DROP + 1;
  localparam int O_PROD_LO   = O_FILL_LO + CNT_W;
  localparam int O_DTOT_LO   = O_PROD_LO + TOT_W;
  localparam int OUT_BITS    = O_DTOT_LO + TOT_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cfg_wr;
    logic push;
    logic clear;
    logic take_empty;
    logic take_load;
    logic rd;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_valid;
    logic n_zero;
    logic rem_one;
  } stat_t;

endpackage
`default_nettype wire

@@ hdl/dosf_ctrl.sv @@
`default_nettype none
module dosf_ctrl
  import dosf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  input  wire logic [FUNC_W-1:0] func,
  input  wire logic              cfg_valid,
  input  wire logic              m_tready,
  input  wire stat_t             stat,
  output logic                   s_tready,
  output logic                   cfg_ready,
  output cmd_t                   cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0] state, state_next;
  logic       out_free;
  logic       fire;

  assign out_free  = !stat.out_valid || m_tready;
  assign cfg_ready = (state == S_IDLE);
  assign s_tready  = (state == S_IDLE) && out_free && !cfg_valid;
  assign fire      = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.cfg_wr = cfg_valid && cfg_ready;
    unique case (state)
      S_IDLE: begin
        if (fire) begin
          unique case (func)
            FUNC_PUSH:  cmd.push = 1'b1;
            FUNC_CLEAR: cmd.clear = 1'b1;
            FUNC_TAKE: begin
              if (stat.n_zero) begin
                cmd.take_empty = 1'b1;
              end else begin
                cmd.take_load = 1'b1;
                state_next    = S_READ;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = stat.rem_one ? S_IDLE : S_READ;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

@@ hdl/dosf_dp.sv @@
`default_nettype none
module dosf_dp
  import dosf_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire cmd_t                   cmd,
  input  wire logic [CNT_W-1:0]       cfg_data,
  input  wire logic [SMP_W-1:0]       sample_in,
  input  wire logic [MAXC_W-1:0]      max_count,
  input  wire logic                   m_tready,
  output stat_t                       stat,
  output logic                        m_tvalid,
  output logic [OUT_TDATA_W-1:0]      m_tdata,
  output logic [KIND_W-1:0]           m_tuser,
  output logic                        m_tlast
);

  logic [SMP_W-1:0] mem [DEPTH];
  logic [SMP_W-1:0] rd_data;

  logic [PTR_W-1:0]  rp;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cap;
  logic [TOT_W-1:0]  prod, dtot;
  logic [TAKE_W-1:0] rem;

  logic              out_valid;
  logic [KIND_W-1:0] out_kind;
  logic [SMP_W-1:0]  out_smp;
  logic              out_last, out_drop;
  logic [CNT_W-1:0]  out_fill;
  logic [TOT_W-1:0]  out_prod, out_dtot;

  logic [CNT_W-1:0]  rp_p1;
  logic [PTR_W-1:0]  rp_adv;
  logic              full;
  logic [PTR_W-1:0]  push_rp;
  logic [CNT_W-1:0]  push_cnt;
  logic [CNT_W:0]    wr_sum, wr_wrap;
  logic [PTR_W-1:0]  wr_addr;
  logic [TOT_W-1:0]  prod_next, dtot_next;
  logic [TAKE_W-1:0] maxc_c, n;
  logic [CNT_W-1:0]  cap_eff;
  logic              load;

  always_comb begin
    rp_p1     = {1'b0, rp} + CNT_W'(1);
    rp_adv    = (rp_p1 >= cap) ? '0 : rp_p1[PTR_W-1:0];
    full      = (cnt >= cap);
    push_rp   = full ? rp_adv : rp;
    push_cnt  = full ? cnt - CNT_W'(1) : cnt;
    wr_sum    = {2'b00, push_rp} + {1'b0, push_cnt};
    wr_wrap   = (wr_sum >= {1'b0, cap}) ? wr_sum - {1'b0, cap} : wr_sum;
    wr_addr   = wr_wrap[PTR_W-1:0];
    prod_next = (prod == TOT_MAX) ? prod : prod + TOT_W'(1);
    dtot_next = (full && dtot != TOT_MAX) ? dtot + TOT_W'(1) : dtot;
    maxc_c    = (max_count > MAXC_W'(MAX_TAKE)) ? TAKE_W'(MAX_TAKE) : TAKE_W'(max_count);
    n         = (CNT_W'(maxc_c) > cnt) ? TAKE_W'(cnt) : maxc_c;
    if (cfg_data == '0) begin
      cap_eff = CNT_W'(1);
    end else if (cfg_data > CNT_W'(DEPTH)) begin
      cap_eff = CNT_W'(DEPTH);
    end else begin
      cap_eff = cfg_data;
    end
  end

  assign load         = cmd.push || cmd.clear || cmd.take_empty || cmd.emit;
  assign stat.out_valid = out_valid;
  assign stat.n_zero  = (n == '0);
  assign stat.rem_one = (rem == TAKE_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_addr] <= sample_in;
    end
    if (cmd.rd) begin
      rd_data <= mem[rp];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rp        <= '0;
      cnt       <= '0;
      cap       <= CAP_RESET;
      prod      <= '0;
      dtot      <= '0;
      rem       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.cfg_wr) begin
        cap <= cap_eff;
        rp  <= '0;
        cnt <= '0;
      end
      if (cmd.push) begin
        rp   <= push_rp;
        cnt  <= push_cnt + CNT_W'(1);
        prod <= prod_next;
        dtot <= dtot_next;
      end
      if (cmd.clear) begin
        rp  <= '0;
        cnt <= '0;
      end
      if (cmd.take_load) begin
        rem <= n;
      end
      if (cmd.emit) begin
        rp  <= rp_adv;
        cnt <= cnt - CNT_W'(1);
        rem <= rem - TAKE_W'(1);
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_prod <= cmd.push ? prod_next : prod;
      out_dtot <= cmd.push ? dtot_next : dtot;
      out_smp  <= cmd.emit ? rd_data : '0;
      out_drop <= cmd.push && full;
      out_last <= cmd.emit ? stat.rem_one : 1'b1;
      if (cmd.push) begin
        out_kind <= KIND_PUSH;
        out_fill <= push_cnt + CNT_W'(1);
      end else if (cmd.clear) begin
        out_kind <= KIND_CLEAR;
        out_fill <= '0;
      end else if (cmd.take_empty) begin
        out_kind <= KIND_EMPTY;
        out_fill <= cnt;
      end else begin
        out_kind <= KIND_DATA;
        out_fill <= cnt - CNT_W'(1);
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;
  assign m_tdata  = {{(OUT_TDATA_W - OUT_BITS){1'b0}}, out_dtot, out_prod, out_fill,
                     out_drop, out_smp};

endmodule
`default_nettype wire

@@ hdl/drop_oldest_sample_fifo_top.sv @@
// Ring-buffer FIFO of 32-bit sample words that overwrites its oldest entry
// when a push finds it full. Each beat on the slave stream is one operation
// selected by s_tuser: push one sample, take up to max_count samples, or
// clear. Every operation answers with beats on the master stream; m_tlast
// marks the final beat that an operation causes.
// A push or a clear is answered in the cycle after it is accepted, and
// pushes can be accepted every cycle while the master side keeps up. A
// take with nothing to return is answered in the cycle after it is
// accepted. A take of n samples holds the slave side from the cycle in
// which it is accepted: for each sample, the controller first does the
// registered read of the sample memory and then loads the output
// register, which waits while the receiver stalls. No other beat is
// accepted until its last sample has been loaded.
// The output register separates the two sides: a new operation is accepted
// while the previous result still waits, as long as that result is taken in
// the same cycle. When the receiver stalls, the result holds in place and
// the slave side stops accepting.
// The capacity register is written over the cfg channel between operations;
// a write empties the ring but keeps the totals. Synchronous reset empties
// the ring, clears both totals and sets the capacity to its full size. No
// clearing pass runs after reset; the sample memory is never read before it
// is written.
`default_nettype none
module drop_oldest_sample_fifo_top
  import dosf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Capacity register write channel.
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CNT_W-1:0]      cfg_data,
  // Slave stream: operations.
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // s_tdata fields from bit 0: sample_in[31:0], max_count[38:32], zero pad.
  input  wire logic [IN_TDATA_W-1:0] s_tdata,
  // s_tuser fields from bit 0: func[1:0].
  input  wire logic [FUNC_W-1:0]     s_tuser,
  // Master stream: results.
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // m_tdata fields from bit 0: sample_out[31:0], dropped_oldest[32],
  // fill_level[43:33], produced_total[91:44], dropped_total[139:92], zero pad.
  output logic [OUT_TDATA_W-1:0]     m_tdata,
  // m_tuser fields from bit 0: kind[1:0].
  output logic [KIND_W-1:0]          m_tuser,
  output logic                       m_tlast
);

  cmd_t  cmd;
  stat_t stat;

  // The controller sequences operations and takes; it never touches data.
  dosf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .func      (s_tuser),
    .cfg_valid (cfg_valid),
    .m_tready  (m_tready),
    .stat      (stat),
    .s_tready  (s_tready),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  // The datapath holds the sample memory, pointers, totals and the output
  // register.
  dosf_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg_data  (cfg_data),
    .sample_in (s_tdata[SMP_W-1:0]),
    .max_count (s_tdata[SMP_W+MAXC_W-1:SMP_W]),
    .m_tready  (m_tready),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule
`default_nettype wire

@@ hdl/dosf_checker.sv @@
`default_nettype none
module dosf_checker
  import dosf_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [OUT_TDATA_W-1:0] m_tdata,
  input wire logic [KIND_W-1:0]     m_tuser,
  input wire logic                  m_tlast
);

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result pending right after reset");

  // A stalled result holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result changed");

  // The fill level never exceeds the ring size.
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[O_PROD_LO-1:O_FILL_LO] <= CNT_W'(DEPTH))
    else $error("fill level above ring size");

  // Only a push reports a drop, and every non-data result ends its operation.
  a_drop_push: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[O_DROP] |-> m_tuser == KIND_PUSH)
    else $error("drop flagged on a non-push result");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != KIND_DATA |-> m_tlast)
    else $error("single-beat result without last");

endmodule

bind drop_oldest_sample_fifo_top dosf_checker u_dosf_checker (.*);
`default_nettype wire
